[rtl/btblp_pkg.sv]
// Shared types, constants and helpers for the branch target buffer with local predictor.
// No dependencies; used by every module in rtl/.
package btblp_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned HIST_W      = 2;
  localparam int unsigned CTRS_PER_E  = 4;

  localparam logic [7:0] PC_NO_MATCH = 8'hFF;
  localparam logic [1:0] CTR_INIT    = 2'd1;
  localparam logic [1:0] CTR_MAX     = 2'd3;
  localparam logic [1:0] CTR_MIN     = 2'd0;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pc;
    logic       taken;
    logic [7:0] target;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_index;
    logic        guess_taken;
    logic [7:0]  predicted_target;
    logic        replaced;
    logic [15:0] replace_count;
  } resp_t;

  // 2-bit saturating counter step
  function automatic logic [1:0] ctr_step(input logic [1:0] c, input logic taken);
    logic [1:0] r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/branch_target_buffer_local_predictor_unit.sv]
// Branch target buffer with 2-level local predictor; depends on btblp_pkg, btblp_table.
// A request passes through the input register, then the result register, on its way
// to the result output.
// Throughput one request per cycle, stalled only by out_ready_i; table state is read and
// written in the single compute stage so back-to-back requests see each other's updates.
// Reset (rst_ni, async, active low) clears valid bits, FIFO pointer and replace count.
module branch_target_buffer_local_predictor_unit #(
  parameter int unsigned Entries = btblp_pkg::ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  btblp_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output btblp_pkg::resp_t out_resp_o
);

  // input register
  logic             s1_valid_q;
  btblp_pkg::req_t  s1_req_q;
  // result register
  logic             out_valid_q;
  btblp_pkg::resp_t out_resp_q;

  logic             advance;   // result register free or being drained
  logic             fire;      // request in stage 1 is processed this cycle
  btblp_pkg::resp_t resp;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  btblp_table #(.Entries(Entries)) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_req_q),
    .resp_o (resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance)    out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_req_q <= in_req_i;
    if (fire)                     out_resp_q <= resp;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a prediction is only given on a hit, and a replacement never reports a hit
  a_resp_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_resp_o.guess_taken || out_resp_o.hit) &&
                     !(out_resp_o.replaced && out_resp_o.hit)))
    else $error("inconsistent result fields");

endmodule

[rtl/btblp_match.sv]
// Associative tag match: lowest valid entry whose tag equals the PC.
// Depends on btblp_pkg.
module btblp_match #(
  parameter int unsigned Entries = btblp_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic [Entries-1:0] valid_i,
  input  logic [7:0]         tag_i [Entries],
  input  logic [7:0]         pc_i,
  output logic               hit_o,
  output logic [IdxW-1:0]    idx_o
);

  // scan downwards so the lowest matching index wins
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_i[i] && (tag_i[i] == pc_i)) begin
        hit_o = 1'b1;
        idx_o = IdxW'(i);
      end
    end
    // reserved PC never matches
    if (pc_i == btblp_pkg::PC_NO_MATCH) begin
      hit_o = 1'b0;
      idx_o = '0;
    end
  end

endmodule

[rtl/btblp_table.sv]
// Entry storage, FIFO replacement, counter training and result forming.
// Depends on btblp_pkg and btblp_match.
module btblp_table #(
  parameter int unsigned Entries = btblp_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  btblp_pkg::req_t   req_i,
  output btblp_pkg::resp_t  resp_o
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [Entries-1:0] valid_q;
  logic [7:0]         tag_q  [Entries];
  logic [7:0]         tgt_q  [Entries];
  logic [btblp_pkg::HIST_W-1:0] hist_q [Entries];
  logic [btblp_pkg::CTRS_PER_E-1:0][1:0] ctr_q [Entries];
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [15:0]        swap_q, swap_d;

  logic               hit;
  logic [IdxW-1:0]    idx;
  logic [btblp_pkg::HIST_W-1:0] hist_sel;
  logic [1:0]         ctr_sel;
  logic [IdxW+3:0]    idx_ext;

  btblp_match #(.Entries(Entries)) u_match (
    .valid_i (valid_q),
    .tag_i   (tag_q),
    .pc_i    (req_i.pc),
    .hit_o   (hit),
    .idx_o   (idx)
  );

  assign hist_sel = hist_q[idx];
  assign ctr_sel  = ctr_q[idx][hist_sel];
  assign idx_ext  = {4'b0000, idx};

  always_comb begin
    resp_o = '0;
    swap_d = swap_q;
    ptr_d  = ptr_q;
    unique case (req_i.op)
      btblp_pkg::OP_LOOKUP, btblp_pkg::OP_UPDATE: begin
        if (hit) begin
          resp_o.hit              = 1'b1;
          resp_o.hit_index        = idx_ext[3:0];
          resp_o.predicted_target = tgt_q[idx];
          resp_o.guess_taken      = (req_i.op == btblp_pkg::OP_LOOKUP) && ctr_sel[1];
        end
      end
      btblp_pkg::OP_INSERT: begin
        resp_o.replaced = valid_q[ptr_q];
        swap_d = swap_q + {15'd0, valid_q[ptr_q]};
        ptr_d  = (ptr_q == IdxW'(Entries - 1)) ? '0 : ptr_q + 1'b1;
      end
      default: ;
    endcase
    resp_o.replace_count = swap_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      swap_q  <= '0;
    end else if (fire_i && (req_i.op == btblp_pkg::OP_INSERT)) begin
      valid_q[ptr_q] <= 1'b1;
      ptr_q          <= ptr_d;
      swap_q         <= swap_d;
    end
  end

  // payload storage; history and counters only read once the entry is valid
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (req_i.op == btblp_pkg::OP_INSERT) begin
        tag_q[ptr_q]  <= req_i.pc;
        tgt_q[ptr_q]  <= req_i.target;
        hist_q[ptr_q] <= '0;
        ctr_q[ptr_q]  <= {btblp_pkg::CTRS_PER_E{btblp_pkg::CTR_INIT}};
      end else if ((req_i.op == btblp_pkg::OP_UPDATE) && hit) begin
        ctr_q[idx][hist_sel] <= btblp_pkg::ctr_step(ctr_sel, req_i.taken);
        hist_q[idx]          <= {hist_sel[btblp_pkg::HIST_W-2:0], req_i.taken};
      end
    end
  end

  // occupancy only grows
  a_valid_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $countones($past(valid_q)))
    else $error("valid entry lost");

  // a hit always points at a valid entry
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> valid_q[idx])
    else $error("hit on invalid entry");

  // replacement counter moves only on a replacing insert
  a_swap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !resp_o.replaced) |=> (swap_q == $past(swap_q)))
    else $error("replace count moved without replacement");

endmodule

[sim/branch_target_buffer_local_predictor_checker.sv]
// Response checker for the branch target buffer with local predictor.
// Watches both request/response channels, keeps its own table model, compares.
// Depends on btblp_pkg.
`timescale 1ns / 1ps

module branch_target_buffer_local_predictor_checker #(
  parameter int unsigned Entries = btblp_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  btblp_pkg::req_t   in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  btblp_pkg::resp_t  out_resp_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       lookup_hits_o
);

  localparam logic [1:0] TAKEN_FLOOR = 2'd2;

  logic        slot_used [Entries];
  logic [7:0]  slot_tag  [Entries];
  logic [7:0]  slot_dest [Entries];
  logic [1:0]  slot_hist [Entries];
  logic [1:0]  pat_ctr   [Entries][btblp_pkg::CTRS_PER_E];
  int unsigned fifo_ptr;
  logic [15:0] swap_total;

  btblp_pkg::resp_t due_resp_q[$];

  // Applies one request to the table copy and returns the response it should give.
  task automatic resolve_request(input btblp_pkg::req_t r, output btblp_pkg::resp_t res);
    int          slot;
    int          i;
    logic [1:0]  hist;
    logic [1:0]  c;
    res  = '0;
    slot = -1;
    if ((r.op == btblp_pkg::OP_LOOKUP || r.op == btblp_pkg::OP_UPDATE) &&
        r.pc != btblp_pkg::PC_NO_MATCH) begin
      // scan downwards so the lowest matching slot wins
      for (i = Entries - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_tag[i] == r.pc) slot = i;
      end
    end
    if (slot >= 0) begin
      hist                 = slot_hist[slot];
      res.hit              = 1'b1;
      res.hit_index        = 4'(slot);
      res.predicted_target = slot_dest[slot];
      if (r.op == btblp_pkg::OP_LOOKUP) begin
        res.guess_taken = (pat_ctr[slot][hist] >= TAKEN_FLOOR);
      end else begin
        c = pat_ctr[slot][hist];
        if (r.taken && c != btblp_pkg::CTR_MAX) c = c + 2'd1;
        else if (!r.taken && c != btblp_pkg::CTR_MIN) c = c - 2'd1;
        pat_ctr[slot][hist] = c;
        slot_hist[slot]     = {hist[0], r.taken};
      end
    end else if (r.op == btblp_pkg::OP_INSERT) begin
      if (slot_used[fifo_ptr]) begin
        swap_total   = swap_total + 16'd1;
        res.replaced = 1'b1;
      end
      slot_used[fifo_ptr] = 1'b1;
      slot_tag[fifo_ptr]  = r.pc;
      slot_dest[fifo_ptr] = r.target;
      slot_hist[fifo_ptr] = '0;
      for (i = 0; i < btblp_pkg::CTRS_PER_E; i++) pat_ctr[fifo_ptr][i] = btblp_pkg::CTR_INIT;
      fifo_ptr = (fifo_ptr + 1) % Entries;
    end
    res.replace_count = swap_total;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    btblp_pkg::resp_t want;
    int    i;
    int    k;
    if (!rst_ni) begin
      for (i = 0; i < Entries; i++) begin
        slot_used[i] = 1'b0;
        slot_tag[i]  = '0;
        slot_dest[i] = '0;
        slot_hist[i] = '0;
        for (k = 0; k < btblp_pkg::CTRS_PER_E; k++) pat_ctr[i][k] = btblp_pkg::CTR_INIT;
      end
      fifo_ptr      = 0;
      swap_total    = '0;
      due_resp_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      lookup_hits_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_resp_q.size() == 0) begin
          $error("response with nothing outstanding: %p", out_resp_i);
          fail_count_o++;
        end else begin
          want = due_resp_q.pop_front();
          compare_field("hit", want.hit, out_resp_i.hit);
          compare_field("hit_index", want.hit_index, out_resp_i.hit_index);
          compare_field("guess_taken", want.guess_taken, out_resp_i.guess_taken);
          compare_field("predicted_target", want.predicted_target,
                        out_resp_i.predicted_target);
          compare_field("replaced", want.replaced, out_resp_i.replaced);
          compare_field("replace_count", want.replace_count, out_resp_i.replace_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        resolve_request(in_req_i, want);
        if (in_req_i.op == btblp_pkg::OP_LOOKUP && want.hit) lookup_hits_o++;
        due_resp_q.push_back(want);
      end
      pending_o = due_resp_q.size();
    end
  end

endmodule

[sim/branch_target_buffer_local_predictor_unit_tb.sv]
// Testbench top for the branch target buffer with local predictor.
// Generates requests and back-pressure; the checker module does all comparison.
// Depends on btblp_pkg, the unit under test and branch_target_buffer_local_predictor_checker.
`timescale 1ns / 1ps

module branch_target_buffer_local_predictor_unit_tb;

  localparam logic [1:0]  OP_RESERVED  = 2'd3;   // no operation, must leave table alone
  localparam int unsigned RANDOM_ITEMS = 1725;
  localparam int unsigned CALM_ITEMS   = 200;    // tail of the run with no idling
  localparam int unsigned SEGMENT_LEN  = 150;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  btblp_pkg::req_t  in_req_i    = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  btblp_pkg::resp_t out_resp_o;

  int unsigned fail_count;
  int unsigned pending_cnt;
  int unsigned lookup_hits;

  // idling controls, changed per segment of the run
  int unsigned src_rate  = 20;
  int unsigned sink_rate = 20;
  bit          calm      = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned cycle_count = 0;

  // per-operation tallies for the summary
  int unsigned n_lookup, n_insert, n_update, n_reserved;

  // recently inserted tags, so most lookups and updates land on live entries
  logic [7:0] recent_pc[$];

  branch_target_buffer_local_predictor_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_resp_o (out_resp_o)
  );

  branch_target_buffer_local_predictor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_resp_i   (out_resp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt),
    .lookup_hits_o(lookup_hits)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Response side: stalls come in bursts.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_ready_i <= 1'b1;
      sink_hold   <= 0;
    end else if (sink_hold != 0) begin
      out_ready_i <= 1'b0;
      sink_hold   <= sink_hold - 1;
    end else if ($urandom_range(0, 99) < sink_rate) begin
      out_ready_i <= 1'b0;
      sink_hold   <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Entered at a rising edge; returns at the edge where the request was taken.
  // Ready is sampled on the falling edge, well clear of the update at the rising one.
  task automatic drive_request(input btblp_pkg::op_e op, input logic [7:0] pc,
                               input logic taken, input logic [7:0] target);
    btblp_pkg::req_t r;
    bit   took;
    r.op     = op;
    r.pc     = pc;
    r.taken  = taken;
    r.target = target;
    if (!calm && $urandom_range(0, 99) < src_rate) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    case (op)
      btblp_pkg::OP_LOOKUP: n_lookup++;
      btblp_pkg::OP_INSERT: begin
        n_insert++;
        recent_pc.push_back(pc);
        if (recent_pc.size() > 16) void'(recent_pc.pop_front());
      end
      btblp_pkg::OP_UPDATE: n_update++;
      default:   n_reserved++;
    endcase
  endtask

  // Drop valid and hold off until every outstanding response has come back.
  // Leaves on a falling edge.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] choose_pc();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 78 && recent_pc.size() != 0)
      return recent_pc[$urandom_range(0, recent_pc.size() - 1)];
    if (roll < 86) return btblp_pkg::PC_NO_MATCH;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned run_len;
    int unsigned kind;
    int unsigned next_seg;
    bit          paused;
    bit          bias;
    logic [7:0]  pc;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Empty table: lookup and update both miss; the spare opcode is inert.
    drive_request(btblp_pkg::OP_LOOKUP, 8'h00, 1'b1, 8'hFF);
    drive_request(btblp_pkg::OP_UPDATE, 8'h00, 1'b1, 8'h00);
    drive_request(btblp_pkg::op_e'(OP_RESERVED), 8'hFF, 1'b1, 8'hFF);
    // Fill: extreme tags and targets; pc FF occupies a slot but never matches.
    drive_request(btblp_pkg::OP_INSERT, 8'h00, 1'b0, 8'h00);
    drive_request(btblp_pkg::OP_INSERT, 8'hFF, 1'b1, 8'hFF);
    drive_request(btblp_pkg::OP_LOOKUP, 8'hFF, 1'b0, 8'h00);
    drive_request(btblp_pkg::OP_UPDATE, 8'hFF, 1'b1, 8'h00);
    drive_request(btblp_pkg::OP_INSERT, 8'hAA, 1'b1, 8'h55);
    // Duplicate tag: slot 0 must keep winning over slot 3.
    drive_request(btblp_pkg::OP_INSERT, 8'h00, 1'b1, 8'hFF);
    drive_request(btblp_pkg::OP_LOOKUP, 8'h00, 1'b0, 8'h00);
    // Train taken until the counter for the all-taken history saturates high, then check the prediction.
    repeat (5) drive_request(btblp_pkg::OP_UPDATE, 8'h00, 1'b1, 8'h00);
    drive_request(btblp_pkg::OP_LOOKUP, 8'h00, 1'b0, 8'h00);
    // Train not-taken down to saturation at zero.
    repeat (5) drive_request(btblp_pkg::OP_UPDATE, 8'h00, 1'b0, 8'h00);
    drive_request(btblp_pkg::OP_LOOKUP, 8'h00, 1'b1, 8'h00);
    drive_request(btblp_pkg::OP_LOOKUP, 8'hAA, 1'b0, 8'h00);
    drive_request(btblp_pkg::op_e'(OP_RESERVED), 8'h00, 1'b0, 8'h00);

    // ---- random part ----
    // Mostly insert-then-train-then-lookup traffic on live tags, with misses,
    // unmatched pc FF and spare opcodes mixed in.
    sent     = 0;
    next_seg = 0;
    paused   = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_seg) begin
        next_seg = sent + SEGMENT_LEN;
        case ($urandom_range(0, 2))
          0: begin src_rate <= 0;  sink_rate <= 0;  end
          1: begin src_rate <= 15; sink_rate <= 15; end
          default: begin src_rate <= 40; sink_rate <= 40; end
        endcase
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
        @(posedge clk_i);
      end
      if (sent + CALM_ITEMS >= RANDOM_ITEMS) calm <= 1'b1;

      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        // re-inserting a live tag now and then creates duplicate matches
        pc = ($urandom_range(0, 3) == 0) ? choose_pc() : 8'($urandom_range(0, 254));
        drive_request(btblp_pkg::OP_INSERT, pc, 1'($urandom), 8'($urandom_range(0, 255)));
        sent++;
      end else if (kind < 45) begin
        // biased training run on one branch, then ask for its prediction
        pc      = choose_pc();
        bias    = 1'($urandom);
        run_len = $urandom_range(2, 8);
        repeat (run_len)
          drive_request(btblp_pkg::OP_UPDATE, pc,
                        ($urandom_range(0, 99) < 85) ? bias : !bias,
                        8'($urandom_range(0, 255)));
        drive_request(btblp_pkg::OP_LOOKUP, pc, 1'($urandom), 8'($urandom_range(0, 255)));
        sent += run_len + 1;
      end else if (kind < 80) begin
        drive_request(btblp_pkg::OP_LOOKUP, choose_pc(), 1'($urandom),
                      8'($urandom_range(0, 255)));
        sent++;
      end else if (kind < 95) begin
        drive_request(btblp_pkg::OP_UPDATE, choose_pc(), 1'($urandom),
                      8'($urandom_range(0, 255)));
        sent++;
      end else begin
        drive_request(btblp_pkg::op_e'(OP_RESERVED), choose_pc(), 1'($urandom),
                      8'($urandom_range(0, 255)));
      end
    end

    // ---- wind down ----
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Covered %0d lookups (%0d hits), %0d inserts, %0d updates, %0d spare-op requests",
             n_lookup, lookup_hits, n_insert, n_update, n_reserved);
    $display("with duplicate tags, unmatched pc FF, counter saturation and FIFO wrap.");
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
